// ===== rtl/core/nrno_pkg.sv =====
// ----------------------------------------------------------------------------
// nrno_pkg
// Shared constants and types for the nearest reference normal orientation block
// ----------------------------------------------------------------------------
package nrno_pkg;

	localparam int COORD_BITS  = 24;
	localparam int NORMAL_BITS = 16;
	localparam int MAX_ENTRIES = 4096;
	localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS    = IDX_BITS + 1;
	localparam int LANE_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * LANE_BITS;
	localparam int SUM_BITS    = PROD_BITS + 2;
	localparam int ENTRY_BITS  = 3 * COORD_BITS + 3 * NORMAL_BITS;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef logic signed [LANE_BITS-1:0] lane_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;

	typedef struct packed {
		logic                vld;
		logic                last;
		logic                dot;
		logic [IDX_BITS-1:0] idx;
	} mac_tag_t;

endpackage

// ===== rtl/core/nrno_if.sv =====
// ----------------------------------------------------------------------------
// nrno_if
// Request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface nrno_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              opcode;
	logic signed [nrno_pkg::COORD_BITS-1:0]  pos_x;
	logic signed [nrno_pkg::COORD_BITS-1:0]  pos_y;
	logic signed [nrno_pkg::COORD_BITS-1:0]  pos_z;
	logic signed [nrno_pkg::NORMAL_BITS-1:0] norm_x;
	logic signed [nrno_pkg::NORMAL_BITS-1:0] norm_y;
	logic signed [nrno_pkg::NORMAL_BITS-1:0] norm_z;

	modport source (
		output valid, opcode, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		input  ready
	);
	modport sink (
		input  valid, opcode, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		output ready
	);
endinterface

interface nrno_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [nrno_pkg::NORMAL_BITS-1:0] out_norm_x;
	logic signed [nrno_pkg::NORMAL_BITS-1:0] out_norm_y;
	logic signed [nrno_pkg::NORMAL_BITS-1:0] out_norm_z;
	logic [11:0]                             nearest_index;
	logic                                    was_flipped;
	logic                                    table_empty;

	modport source (
		output valid, out_norm_x, out_norm_y, out_norm_z, nearest_index,
		       was_flipped, table_empty,
		input  ready
	);
	modport sink (
		input  valid, out_norm_x, out_norm_y, out_norm_z, nearest_index,
		       was_flipped, table_empty,
		output ready
	);
endinterface

// ===== rtl/core/nearest_reference_normal_orient.sv =====
// ----------------------------------------------------------------------------
// nearest_reference_normal_orient
// Reference table with brute-force nearest search and normal orientation
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   opcode, pos_x/y/z, norm_x/y/z
//  rsp      out  out_norm_x/y/z, nearest_index, was_flipped, table_empty
//  cfg      in   cfg_we, cfg_wdata (normal_mode)
//
// load and clear complete in the idle state; a query scans all loaded entries through
// the single table read port, which feeds one entry per cycle into the mac unit.
// a query on an empty table skips the scan and goes straight to the done state.
// req.ready is high only while idle; a finished result waits in the rsp
// register while loads and clears go on, and a query result waits for it.
// reset empties the table and sets orient mode.
// ----------------------------------------------------------------------------
module nearest_reference_normal_orient (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_wdata,
	nrno_req_if.sink   req,
	nrno_rsp_if.source rsp
);

	localparam int CB = nrno_pkg::COORD_BITS;
	localparam int NB = nrno_pkg::NORMAL_BITS;
	localparam int IB = nrno_pkg::IDX_BITS;
	localparam int CN = nrno_pkg::CNT_BITS;
	localparam int LB = nrno_pkg::LANE_BITS;
	localparam int EB = nrno_pkg::ENTRY_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_DOT,
		ST_DOTWAIT,
		ST_DONE
	} state_t;

	function automatic logic signed [NB-1:0] norm_neg(input logic signed [NB-1:0] v);
		logic signed [NB-1:0] most_neg;
		most_neg = {1'b1, {(NB-1){1'b0}}};
		return (v == most_neg) ? {1'b0, {(NB-1){1'b1}}} : -v;
	endfunction

	state_t                  state_q;
	logic [CN-1:0]           cnt_q;
	logic                    mode_q;
	logic [IB-1:0]           scan_addr_q;
	logic [IB-1:0]           best_idx_q;
	nrno_pkg::sum_t          best_d_q;
	logic signed [CB-1:0]    qpos_q [3];
	logic signed [NB-1:0]    qnorm_q [3];
	logic signed [NB-1:0]    refn_q [3];
	logic                    empty_q;
	logic                    flip_q;
	logic                    rsp_valid_q;
	logic signed [NB-1:0]    onorm_q [3];
	logic [IB-1:0]           oidx_q;
	logic                    oflip_q;
	logic                    oempty_q;

	logic [EB-1:0]           entry_mem_q [nrno_pkg::MAX_ENTRIES];
	logic [EB-1:0]           rd_data_s1;
	nrno_pkg::mac_tag_t      rd_tag_s1;
	nrno_pkg::mac_tag_t      diff_tag_s2;
	nrno_pkg::lane_t         diff_s2 [3];

	logic                    req_fire;
	logic                    rsp_fire;
	logic                    mem_we;
	logic                    not_full;
	logic [IB-1:0]           rd_addr;
	logic [IB-1:0]           last_addr;
	logic signed [CB-1:0]    rd_pos [3];
	logic signed [NB-1:0]    rd_norm [3];
	nrno_pkg::mac_tag_t      u_tag_in;
	nrno_pkg::lane_t         u_a [3];
	nrno_pkg::lane_t         u_b [3];
	nrno_pkg::mac_tag_t      u_tag;
	nrno_pkg::sum_t          u_sum;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = rsp_valid_q && rsp.ready;
	assign not_full  = (cnt_q < CN'(nrno_pkg::MAX_ENTRIES));
	assign mem_we    = req_fire && (req.opcode == nrno_pkg::OP_LOAD) && not_full;
	assign rd_addr   = (state_q == ST_FETCH) ? best_idx_q : scan_addr_q;
	assign last_addr = IB'(cnt_q - CN'(1));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rd_pos[k]  = $signed(rd_data_s1[EB-1-k*CB -: CB]);
			rd_norm[k] = $signed(rd_data_s1[3*NB-1-k*NB -: NB]);
		end
	end

	// table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[cnt_q[IB-1:0]] <= {req.pos_x, req.pos_y, req.pos_z,
				req.norm_x, req.norm_y, req.norm_z};
		end
		rd_data_s1 <= entry_mem_q[rd_addr];
	end

	// scan pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_s1   <= '0;
			diff_tag_s2 <= '0;
		end else begin
			rd_tag_s1.vld  <= (state_q == ST_SCAN);
			rd_tag_s1.last <= (scan_addr_q == last_addr);
			rd_tag_s1.dot  <= 1'b0;
			rd_tag_s1.idx  <= scan_addr_q;
			diff_tag_s2    <= rd_tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			diff_s2[k] <= LB'(qpos_q[k]) - LB'(rd_pos[k]);
		end
	end

	// shared unit input select
	always_comb begin
		if (state_q == ST_DOT) begin
			u_tag_in = '{vld: 1'b1, last: 1'b1, dot: 1'b1, idx: '0};
			for (int k = 0; k < 3; k++) begin
				u_a[k] = LB'(qnorm_q[k]);
				u_b[k] = LB'(rd_norm[k]);
			end
		end else begin
			u_tag_in = diff_tag_s2;
			for (int k = 0; k < 3; k++) begin
				u_a[k] = diff_s2[k];
				u_b[k] = diff_s2[k];
			end
		end
	end

	nrno_mac3 u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (u_tag_in),
		.a_in    (u_a),
		.b_in    (u_b),
		.tag_out (u_tag),
		.sum_out (u_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_addr_q <= '0;
			best_idx_q  <= '0;
			best_d_q    <= '0;
			qpos_q      <= '{default: '0};
			qnorm_q     <= '{default: '0};
			refn_q      <= '{default: '0};
			empty_q     <= 1'b0;
			flip_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			onorm_q     <= '{default: '0};
			oidx_q      <= '0;
			oflip_q     <= 1'b0;
			oempty_q    <= 1'b0;
		end else begin
			if (rsp_fire && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			if (u_tag.vld && !u_tag.dot) begin
				if ((u_tag.idx == '0) || (u_sum < best_d_q)) begin
					best_d_q   <= u_sum;
					best_idx_q <= u_tag.idx;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (req.opcode)
							nrno_pkg::OP_LOAD: begin
								if (not_full) begin
									cnt_q <= cnt_q + CN'(1);
								end
							end
							nrno_pkg::OP_CLEAR: begin
								cnt_q <= '0;
							end
							nrno_pkg::OP_QUERY: begin
								qpos_q  <= '{req.pos_x, req.pos_y, req.pos_z};
								qnorm_q <= '{req.norm_x, req.norm_y, req.norm_z};
								if (cnt_q == '0) begin
									empty_q    <= 1'b1;
									flip_q     <= 1'b0;
									best_idx_q <= '0;
									refn_q     <= '{default: '0};
									state_q    <= ST_DONE;
								end else begin
									empty_q     <= 1'b0;
									scan_addr_q <= '0;
									state_q     <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_addr_q <= scan_addr_q + IB'(1);
					if (scan_addr_q == last_addr) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (u_tag.vld && !u_tag.dot && u_tag.last) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_DOT;
				end
				ST_DOT: begin
					refn_q  <= rd_norm;
					state_q <= ST_DOTWAIT;
				end
				ST_DOTWAIT: begin
					if (u_tag.vld && u_tag.dot) begin
						flip_q  <= !mode_q && (u_sum < 0);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						for (int k = 0; k < 3; k++) begin
							if (mode_q) begin
								onorm_q[k] <= refn_q[k];
							end else if (flip_q) begin
								onorm_q[k] <= norm_neg(qnorm_q[k]);
							end else begin
								onorm_q[k] <= qnorm_q[k];
							end
						end
						oidx_q   <= best_idx_q;
						oflip_q  <= flip_q;
						oempty_q <= empty_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.out_norm_x    = onorm_q[0];
	assign rsp.out_norm_y    = onorm_q[1];
	assign rsp.out_norm_z    = onorm_q[2];
	assign rsp.nearest_index = 12'(oidx_q);
	assign rsp.was_flipped   = oflip_q;
	assign rsp.table_empty   = oempty_q;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CN'(nrno_pkg::MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !u_tag.vld)
		else $error("mac unit busy while idle");

	a_load_inc: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (cnt_q == $past(cnt_q) + CN'(1)))
		else $error("load did not advance entry count");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && oempty_q) |-> ((oidx_q == '0) && !oflip_q))
		else $error("empty table result carries index or flip");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && !empty_q) |-> (CN'(best_idx_q) < cnt_q))
		else $error("nearest index outside loaded entries");

endmodule

// ===== rtl/core/nrno_mac3.sv =====
// ----------------------------------------------------------------------------
// nrno_mac3
// Shared two-stage three-lane multiply and sum, used for distances and dots
// ----------------------------------------------------------------------------
module nrno_mac3 (
	input  logic               clk,
	input  logic               arst_n,
	input  nrno_pkg::mac_tag_t tag_in,
	input  nrno_pkg::lane_t    a_in [3],
	input  nrno_pkg::lane_t    b_in [3],
	output nrno_pkg::mac_tag_t tag_out,
	output nrno_pkg::sum_t     sum_out
);

	nrno_pkg::mac_tag_t                    tag_s1;
	nrno_pkg::mac_tag_t                    tag_s2;
	logic signed [nrno_pkg::PROD_BITS-1:0] prod_s1 [3];
	nrno_pkg::sum_t                        sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s1[k] <= a_in[k] * b_in[k];
		end
		sum_s2 <= nrno_pkg::SUM_BITS'(prod_s1[0]) + nrno_pkg::SUM_BITS'(prod_s1[1])
			+ nrno_pkg::SUM_BITS'(prod_s1[2]);
	end

	assign tag_out = tag_s2;
	assign sum_out = sum_s2;

endmodule
